// File: rtl/lrsgd_pkg.sv
package lrsgd_pkg;

   // Sizing
   localparam int MAX_FEATURES    = 8;
   localparam int SIGMOID_ENTRIES = 256;
   localparam int WIDX_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int CNT_W   = $clog2(MAX_FEATURES + 1);
   localparam int TIDX_W  = $clog2(SIGMOID_ENTRIES);
   localparam int PROD_W  = 48;
   localparam int ACC_W   = PROD_W + CNT_W;
   localparam int LRE_W   = 35;
   localparam int UPD_W   = LRE_W + 16;
   // sum - lo is a 28-bit value; top TIDX_W bits form the table index
   localparam int IDX_SHIFT = 28 - TIDX_W;

   // Config register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] REG_LEARNING_RATE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_FEATURE_COUNT = 1'd1;

   typedef enum logic [1:0] {
      MODE_PREDICT = 2'd0,
      MODE_TRAIN   = 2'd1,
      MODE_WRITE   = 2'd2,
      MODE_UNUSED  = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DOT,
      ST_INDEX,
      ST_TABLE,
      ST_ERR,
      ST_UPDATE,
      ST_WRITE,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [15:0] feature_0;
      logic signed [15:0] feature_1;
      logic signed [15:0] feature_2;
      logic signed [15:0] feature_3;
      logic signed [15:0] feature_4;
      logic signed [15:0] feature_5;
      logic signed [15:0] feature_6;
      logic signed [15:0] feature_7;
      logic               label;
      logic [2:0]         weight_index;
      logic signed [31:0] weight_value;
   } req_data_type;

   typedef struct packed {
      logic [15:0] probability;
      logic        predicted_class;
      logic        mismatch;
   } rsp_data_type;

   // Controller to datapath
   typedef struct packed {
      logic             clear;
      logic             dot_mul;
      logic             dot_acc;
      logic             make_index;
      logic             lookup;
      logic             make_err;
      logic             upd_mul;
      logic             upd_wr;
      logic             write_w;
      logic             load_rsp;
      logic             zero_rsp;
      logic [WIDX_W-1:0] mul_idx;
      logic [WIDX_W-1:0] wr_idx;
   } cmd_type;

   typedef logic [15:0] sig_table_type [SIGMOID_ENTRIES];

   // Unsigned quotient by shift and subtract, for building the table
   function automatic longint unsigned udiv64(input longint unsigned num,
                                              input longint unsigned den);
      longint unsigned q;
      longint unsigned r;
      q = '0;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], num[b]};
         if (r >= den) begin
            r    = r - den;
            q[b] = 1'b1;
         end
      end
      return q;
   endfunction

   // One sigmoid entry, evaluated at the interval midpoint (Q32 exp series)
   function automatic logic [15:0] sigmoid_entry(input int unsigned i);
      longint                mid;
      longint unsigned       mag;
      longint unsigned       whole;
      longint unsigned       frac;
      longint unsigned       ip;
      longint unsigned       term;
      longint                fp;
      logic [127:0]          wide;
      longint unsigned       e;
      longint unsigned       d;
      longint unsigned       s;
      mid = ((longint'(2 * i + 1) * 64'sd34359738368) >>> TIDX_W)
            - 64'sd34359738368;
      mag = (mid < 0) ? longint'(-mid) : longint'(mid);
      whole = mag >> 32;
      frac  = mag & 64'hFFFF_FFFF;
      ip    = 64'h1_0000_0000;
      term  = 64'h1_0000_0000;
      fp    = 64'sh1_0000_0000;
      for (longint unsigned k = 0; k < whole; k++) begin
         ip = (ip * 64'd1580030169 + 64'h8000_0000) >> 32;
      end
      for (int k = 1; k <= 14; k++) begin
         wide = 128'(term) * 128'(frac);
         term = udiv64(wide[95:32], 64'(k));
         if (k[0]) begin
            fp = fp - longint'(term);
         end else begin
            fp = fp + longint'(term);
         end
      end
      if (fp < 0) begin
         fp = 0;
      end
      wide = 128'(fp) * 128'(ip) + 128'h8000_0000;
      e = wide[95:32];
      d = 64'h1_0000_0000 + e;
      s = udiv64(64'h1_0000_0000_0000 + (d >> 1), d);
      if (mid < 0) begin
         s = 64'd65536 - s;
      end
      if (s > 64'd65535) begin
         s = 64'd65535;
      end
      return s[15:0];
   endfunction

   function automatic sig_table_type build_sigmoid_table();
      sig_table_type t;
      for (int i = 0; i < SIGMOID_ENTRIES; i++) begin
         t[i] = sigmoid_entry(i);
      end
      return t;
   endfunction

   localparam sig_table_type SIGMOID_TABLE = build_sigmoid_table();

endpackage

// File: rtl/lrsgd_ctrl.sv
module lrsgd_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic [1:0]                        req_mode,
   output logic                              req_ready,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  logic                              csr_we,
   input  logic [lrsgd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                       csr_wdata,
   output lrsgd_pkg::cmd_type                cmd
);
   import lrsgd_pkg::*;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]       mode_ff, mode_in;
   logic [3:0]       fc_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] n_feat;
   logic [CNT_W-1:0] cnt_dec;

   // active feature count, clipped to the weight store size
   assign n_feat = (fc_ff > 4'(MAX_FEATURES)) ? CNT_W'(MAX_FEATURES) : CNT_W'(fc_ff);
   assign cnt_dec = cnt_ff - CNT_W'(1);
   assign rsp_valid = rsp_valid_ff;

   // feature count register
   always_ff @(posedge clock) begin
      if (reset) begin
         fc_ff <= 4'd6;
      end else if (csr_we && csr_index == REG_FEATURE_COUNT) begin
         fc_ff <= csr_wdata[3:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         mode_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      mode_in      = mode_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      cmd.mul_idx  = cnt_ff[WIDX_W-1:0];
      cmd.wr_idx   = cnt_dec[WIDX_W-1:0];
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.clear = 1'b1;
               mode_in   = req_mode;
               cnt_in    = '0;
               if (req_mode == MODE_PREDICT || req_mode == MODE_TRAIN) begin
                  state_in = ST_DOT;
               end else if (req_mode == MODE_WRITE) begin
                  state_in = ST_WRITE;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_DOT: begin
            cmd.dot_mul = (cnt_ff < n_feat);
            cmd.dot_acc = (cnt_ff != '0);
            if (cnt_ff == n_feat) begin
               state_in = ST_INDEX;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_INDEX: begin
            cmd.make_index = 1'b1;
            state_in = ST_TABLE;
         end
         ST_TABLE: begin
            cmd.lookup = 1'b1;
            state_in = (mode_ff == MODE_TRAIN) ? ST_ERR : ST_DONE;
         end
         ST_ERR: begin
            cmd.make_err = 1'b1;
            cnt_in   = '0;
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.upd_mul = (cnt_ff < n_feat);
            cmd.upd_wr  = (cnt_ff != '0);
            if (cnt_ff == n_feat) begin
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_WRITE: begin
            cmd.write_w = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               cmd.zero_rsp = !(mode_ff == MODE_PREDICT || mode_ff == MODE_TRAIN);
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/lrsgd_datapath.sv
module lrsgd_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  lrsgd_pkg::req_data_type      req_data,
   input  lrsgd_pkg::cmd_type           cmd,
   input  logic                         csr_we,
   input  logic [lrsgd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0]                  csr_wdata,
   output lrsgd_pkg::rsp_data_type      rsp_data
);
   import lrsgd_pkg::*;

   req_data_type             item_ff;
   logic signed [31:0]       weight_ff [MAX_FEATURES];
   logic [15:0]              lr_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic [TIDX_W-1:0]        idx_ff;
   logic [15:0]              p_ff;
   logic signed [LRE_W-1:0]  lre_ff;
   logic signed [UPD_W-1:0]  upd_ff;
   rsp_data_type             rsp_ff;

   logic signed [15:0]       feat [8];
   logic signed [15:0]       x_sel;
   logic signed [ACC_W-1:0]  acc_clamped;
   logic [27:0]              acc_offset;
   logic signed [17:0]       err;
   logic signed [UPD_W-1:0]  upd_round;
   logic signed [UPD_W-1:0]  delta;
   logic signed [UPD_W:0]    w_diff;
   logic signed [31:0]       w_sat;
   logic                     cls;

   localparam logic signed [ACC_W-1:0] SUM_LO = -(ACC_W'(1) <<< 27);
   localparam logic signed [ACC_W-1:0] SUM_HI = (ACC_W'(1) <<< 27) - ACC_W'(1);

   assign feat[0] = item_ff.feature_0;
   assign feat[1] = item_ff.feature_1;
   assign feat[2] = item_ff.feature_2;
   assign feat[3] = item_ff.feature_3;
   assign feat[4] = item_ff.feature_4;
   assign feat[5] = item_ff.feature_5;
   assign feat[6] = item_ff.feature_6;
   assign feat[7] = item_ff.feature_7;
   assign x_sel   = feat[cmd.mul_idx];

   // clamp to [-8, 8) and form the table index
   always_comb begin
      if (acc_ff < SUM_LO) begin
         acc_clamped = SUM_LO;
      end else if (acc_ff > SUM_HI) begin
         acc_clamped = SUM_HI;
      end else begin
         acc_clamped = acc_ff;
      end
      acc_offset = 28'(acc_clamped - SUM_LO);
   end

   // error and rounded weight step with saturation
   assign err       = $signed({2'b00, p_ff}) - (item_ff.label ? 18'sd65536 : 18'sd0);
   assign upd_round = upd_ff + (UPD_W'(1) <<< 23);
   assign delta     = upd_round >>> 24;
   assign w_diff    = (UPD_W+1)'(weight_ff[cmd.wr_idx]) - (UPD_W+1)'(delta);
   always_comb begin
      if (w_diff > (UPD_W+1)'(32'sh7FFF_FFFF)) begin
         w_sat = 32'sh7FFF_FFFF;
      end else if (w_diff < -((UPD_W+1)'(1) <<< 31)) begin
         w_sat = 32'sh8000_0000;
      end else begin
         w_sat = w_diff[31:0];
      end
   end

   assign cls = (p_ff > 16'd32768);

   // learning rate register
   always_ff @(posedge clock) begin
      if (reset) begin
         lr_ff <= 16'd655;
      end else if (csr_we && csr_index == REG_LEARNING_RATE) begin
         lr_ff <= csr_wdata;
      end
   end

   // weight store
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_FEATURES; i++) begin
            weight_ff[i] <= '0;
         end
      end else if (cmd.write_w) begin
         if ({1'b0, item_ff.weight_index} < 4'(MAX_FEATURES)) begin
            weight_ff[item_ff.weight_index[WIDX_W-1:0]] <= item_ff.weight_value;
         end
      end else if (cmd.upd_wr) begin
         weight_ff[cmd.wr_idx] <= w_sat;
      end
   end

   // multiply, accumulate, table lookup and response registers
   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         item_ff <= req_data;
         acc_ff  <= '0;
      end else if (cmd.dot_acc) begin
         acc_ff <= acc_ff + ACC_W'(prod_ff);
      end
      if (cmd.dot_mul) begin
         prod_ff <= PROD_W'(weight_ff[cmd.mul_idx]) * PROD_W'(x_sel);
      end
      if (cmd.make_index) begin
         idx_ff <= acc_offset[27 -: TIDX_W];
      end
      if (cmd.lookup) begin
         p_ff <= SIGMOID_TABLE[idx_ff];
      end
      if (cmd.make_err) begin
         lre_ff <= LRE_W'($signed({1'b0, lr_ff})) * LRE_W'(err);
      end
      if (cmd.upd_mul) begin
         upd_ff <= UPD_W'(lre_ff) * UPD_W'(x_sel);
      end
      if (cmd.load_rsp) begin
         if (cmd.zero_rsp) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff.probability     <= p_ff;
            rsp_ff.predicted_class <= cls;
            rsp_ff.mismatch        <= cls ^ item_ff.label;
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule

// File: rtl/logistic_regression_sgd_unit.sv
// Channel   Ports                              Moves
// request   req_valid / req_ready / req_data   one item: mode, features, label, weight
// response  rsp_valid / rsp_ready / rsp_data   probability, class, mismatch
// config    csr_we / csr_index / csr_wdata     learning_rate (0), feature_count (1)
//
// Per item, n active features (up to 8): predict and train walk the weights
// once for the dot product, then one table read; train walks them once more
// for the weight update, on its own multipliers.
// One item at a time; the next is taken as soon as the result reaches the output
// register, even while that result waits for rsp_ready.
// Reset (synchronous): weights zero, learning_rate 655, feature_count 6.
module logistic_regression_sgd_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  lrsgd_pkg::req_data_type           req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output lrsgd_pkg::rsp_data_type           rsp_data,
   input  logic                              csr_we,
   input  logic [lrsgd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [15:0]                       csr_wdata
);
   import lrsgd_pkg::*;

   cmd_type cmd;

   lrsgd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_data.mode),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd)
   );

   lrsgd_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_data  (rsp_data)
   );

endmodule

// File: rtl/lrsgd_checker.sv
module lrsgd_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input lrsgd_pkg::req_data_type           req_data,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input lrsgd_pkg::rsp_data_type           rsp_data,
   input logic                              csr_we,
   input logic [lrsgd_pkg::CSR_IDX_W-1:0]   csr_index,
   input logic [15:0]                       csr_wdata
);
   import lrsgd_pkg::*;

   // no response straight out of reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // one item in flight: busy right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while busy");

   // a stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled response changed");

   // class follows the probability
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.predicted_class == (rsp_data.probability > 16'd32768)))
      else $error("class disagrees with probability");

endmodule

bind logistic_regression_sgd_unit lrsgd_checker u_lrsgd_checker (.*);

// File: tb/logistic_regression_sgd_unit_tb.sv
`timescale 1ns / 100ps

import lrsgd_pkg::*;

// Tracks the unit's weights and settings and queues the expected predictions.
class lr_prediction_board;
   logic [15:0]        rate;
   logic [3:0]         count;
   logic signed [31:0] w [8];
   rsp_data_type       pending [$];
   logic [15:0]        sig_lut [256];
   int                 errors;

   function new();
      rate = 16'd655;
      count = 4'd6;
      errors = 0;
      for (int i = 0; i < 8; i++) w[i] = 0;
      for (int i = 0; i < 256; i++) sig_lut[i] = sig_value(i);
   endfunction

   // exp(-a) in Q32 for a >= 0, a below 9.0
   function automatic longint unsigned exp_q32(longint unsigned a);
      longint unsigned ip, term, frac, e;
      longint          fp;
      logic [127:0]    wide;
      ip = 64'h1_0000_0000;
      term = 64'h1_0000_0000;
      fp = 64'sh1_0000_0000;
      frac = a & 64'hFFFF_FFFF;
      for (longint unsigned k = 0; k < (a >> 32); k++)
         ip = (ip * 64'd1580030169 + 64'h8000_0000) >> 32;
      for (int k = 1; k <= 14; k++) begin
         wide = 128'(term) * 128'(frac);
         term = wide[95:32] / longint'(k);
         if (k % 2 == 1) fp = fp - longint'(term);
         else fp = fp + longint'(term);
      end
      if (fp < 0) fp = 0;
      wide = 128'(fp) * 128'(ip) + 128'h8000_0000;
      e = wide[95:32];
      return e;
   endfunction

   function automatic logic [15:0] sig_value(int i);
      longint          mid;
      longint unsigned mag, d, s;
      mid = (longint'(2 * i + 1) * 64'sd34359738368) / 256 - 64'sd34359738368;
      mag = (mid < 0) ? longint'(-mid) : longint'(mid);
      d = 64'h1_0000_0000 + exp_q32(mag);
      s = (64'h1_0000_0000_0000 + d / 2) / d;
      if (mid < 0) s = 64'd65536 - s;
      if (s > 65535) s = 65535;
      return s[15:0];
   endfunction

   function void set_reg(logic idx, logic [15:0] v);
      if (idx == REG_LEARNING_RATE) rate = v;
      else count = v[3:0];
   endfunction

   function void note_request(req_data_type r);
      rsp_data_type       o;
      logic signed [15:0] x [8];
      longint             acc, err, prod, delta, nw;
      int                 n, idx;
      o = '0;
      x = '{r.feature_0, r.feature_1, r.feature_2, r.feature_3,
            r.feature_4, r.feature_5, r.feature_6, r.feature_7};
      n = (count > 8) ? 8 : count;
      if (r.mode == MODE_WRITE) begin
         w[r.weight_index] = r.weight_value;
      end else if (r.mode == MODE_PREDICT || r.mode == MODE_TRAIN) begin
         acc = 0;
         for (int i = 0; i < n; i++) acc += longint'(w[i]) * longint'(x[i]);
         if (acc < -(64'sd8 <<< 24)) acc = -(64'sd8 <<< 24);
         if (acc > (64'sd8 <<< 24) - 1) acc = (64'sd8 <<< 24) - 1;
         idx = int'(((acc + (64'sd8 <<< 24)) * 256) >>> 28);
         if (idx > 255) idx = 255;
         o.probability = sig_lut[idx];
         o.predicted_class = o.probability > 16'd32768;
         o.mismatch = o.predicted_class != r.label;
         if (r.mode == MODE_TRAIN) begin
            err = longint'(o.probability) - (r.label ? 65536 : 0);
            for (int i = 0; i < n; i++) begin
               prod = longint'(rate) * err * longint'(x[i]) + (64'sd1 <<< 23);
               delta = prod >>> 24;  // arithmetic shift floors
               nw = longint'(w[i]) - delta;
               if (nw > 64'sd2147483647) nw = 64'sd2147483647;
               if (nw < -64'sd2147483648) nw = -64'sd2147483648;
               w[i] = nw[31:0];
            end
         end
      end
      pending = {pending, o};
   endfunction

   // one line per mismatch, counted
   task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
   endtask

   task check_response(rsp_data_type got);
      rsp_data_type e;
      if (pending.size() == 0) begin
         report("response with none pending");
         return;
      end
      e = pending.pop_front();
      if (got.probability !== e.probability)
         report($sformatf("probability %0d, want %0d", got.probability, e.probability));
      if (got.predicted_class !== e.predicted_class)
         report($sformatf("class %0b, want %0b", got.predicted_class, e.predicted_class));
      if (got.mismatch !== e.mismatch)
         report($sformatf("mismatch %0b, want %0b", got.mismatch, e.mismatch));
   endtask
endclass

module logistic_regression_sgd_unit_tb;
   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   req_data_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   rsp_data_type rsp_data;
   logic         csr_we;
   logic         csr_index;
   logic [15:0]  csr_wdata;

   lr_prediction_board board;
   int  idle_cycles = 0;
   bit  quiet_rsp;

   logistic_regression_sgd_unit dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // watchdog: cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // response side: random stalls, check each transfer
   initial begin
      int gap;
      rsp_ready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         gap = quiet_rsp ? 0 : $urandom_range(0, 18);
         repeat (gap) @(negedge clock);
         rsp_ready = 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         board.check_response(rsp_data);
         @(negedge clock);
         rsp_ready = 0;
      end
   end

   task automatic write_reg(logic idx, logic [15:0] v);
      csr_we = 1;
      csr_index = idx;
      csr_wdata = v;
      board.set_reg(idx, v);
      @(negedge clock);
      csr_we = 0;
   endtask

   task automatic send_item(req_data_type r, bit no_gap);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 18);
      repeat (gap) @(negedge clock);
      req_valid = 1;
      req_data = r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(r);
      @(negedge clock);
      req_valid = 0;
   endtask

   // drain outstanding results, then let the unit settle
   task automatic wait_drain();
      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   function automatic req_data_type make_item(logic [1:0] m, bit narrow);
      req_data_type r;
      logic [191:0] bits;
      bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = bits[$bits(req_data_type)-1:0];
      r.mode = m;
      // modest features keep the sum off the clamp most of the time
      if (narrow) begin
         r.feature_0 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.feature_1 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.feature_2 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.feature_3 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.feature_4 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.feature_5 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.feature_6 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.feature_7 = 16'($signed($urandom_range(0, 2047)) - 1024);
         r.weight_value = $signed($urandom_range(0, 262143)) - 131072;
      end
      return r;
   endfunction

   initial begin
      req_data_type r;
      logic [15:0] rates [4];
      int sel;
      board = new();
      reset = 1;
      req_valid = 0;
      req_data = '0;
      csr_we = 0;
      csr_index = REG_LEARNING_RATE;
      csr_wdata = 0;
      quiet_rsp = 0;
      repeat (4) @(negedge clock);
      reset = 0;

      // directed: reset settings, extremes, every mode
      r = '0;
      r.mode = MODE_PREDICT;
      send_item(r, 0);
      r.mode = MODE_UNUSED;
      r.label = 1;
      send_item(r, 0);
      r = '0;
      r.mode = MODE_WRITE;
      r.weight_index = 3'd0;
      r.weight_value = 32'sh7FFF_FFFF;
      send_item(r, 0);
      r.weight_index = 3'd7;
      r.weight_value = 32'sh8000_0000;
      send_item(r, 0);
      r = '0;
      r.mode = MODE_PREDICT;
      r.feature_0 = 16'sh7FFF;
      send_item(r, 0);
      r.feature_0 = 16'sh8000;
      r.label = 1;
      send_item(r, 0);
      r.mode = MODE_TRAIN;
      r.feature_0 = 16'sh8000;
      send_item(r, 1);
      r.feature_0 = 16'sh7FFF;
      r.label = 0;
      send_item(r, 1);
      r = '1;
      r.mode = MODE_TRAIN;
      send_item(r, 0);
      wait_drain();
      write_reg(REG_FEATURE_COUNT, 16'd0);
      write_reg(REG_LEARNING_RATE, 16'hFFFF);
      r.mode = MODE_TRAIN;
      send_item(r, 0);
      r.mode = MODE_PREDICT;
      send_item(r, 0);
      wait_drain();
      write_reg(REG_FEATURE_COUNT, 16'd15);
      r = make_item(MODE_TRAIN, 0);
      send_item(r, 0);
      send_item(make_item(MODE_PREDICT, 0), 0);
      wait_drain();
      write_reg(REG_FEATURE_COUNT, 16'd8);
      write_reg(REG_LEARNING_RATE, 16'd0);
      send_item(make_item(MODE_TRAIN, 1), 0);
      send_item(make_item(MODE_PREDICT, 1), 0);

      // random phases over settings
      rates = '{16'd0, 16'd655, 16'd8000, 16'hFFFF};
      for (int ph = 0; ph < 12; ph++) begin
         wait_drain();
         write_reg(REG_LEARNING_RATE, rates[$urandom_range(0, 3)]);
         write_reg(REG_FEATURE_COUNT, (ph == 0) ? 16'd1 : 16'($urandom_range(0, 15)));
         quiet_rsp = (ph % 4 == 3);
         // rewrite weights with modest values often so training goes somewhere
         if ($urandom_range(0, 1)) begin
            for (int i = 0; i < 8; i++) begin
               r = make_item(MODE_WRITE, 1);
               r.weight_index = 3'(i);
               send_item(r, ph % 4 == 3);
            end
         end
         for (int k = 0; k < 45; k++) begin
            sel = $urandom_range(0, 19);
            if (sel < 9) r = make_item(MODE_TRAIN, sel != 0);
            else if (sel < 16) r = make_item(MODE_PREDICT, sel != 9);
            else if (sel < 19) r = make_item(MODE_WRITE, sel != 16);
            else r = make_item(MODE_UNUSED, 0);
            send_item(r, ph % 4 == 3);
            if (k == 20 && ph == 2) begin
               // sender holds off until all results are back
               while (board.pending.size() != 0) @(negedge clock);
            end
         end
      end
      quiet_rsp = 0;
      wait_drain();
      if (board.errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end
endmodule
